// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the locator design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== sv/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg
// Types, constants and helpers shared by the simplex point locator.
// ----------------------------------------------------------------------------
package spl_pkg;

   localparam int NDIM              = 3;
   localparam int NSLOTS            = NDIM + 1;
   localparam int TWORDS            = NDIM * (NDIM + 1);
   localparam int OFS_BASE          = NDIM * NDIM;
   localparam int MAX_SIMPLICES_DEF = 1024;

   localparam int CNT_W     = 11;
   localparam int IDX_W     = 10;
   localparam int TOL_W     = 25;
   localparam int Q_W       = 32;
   localparam int CUR_W     = 12;
   localparam int NBR_W     = 11;
   localparam int ACC_W     = 44;
   localparam int CSR_W     = 25;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] LAST_K = 2'(NDIM);
   localparam logic [1:0] LAST_J = 2'(NDIM - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd2;

   localparam logic [TOL_W-1:0] TOL_RESET = 25'd16;

   typedef enum logic [1:0] {
      OP_TRANSFORM = 2'd0,
      OP_NEIGHBOR  = 2'd1,
      OP_VALID     = 2'd2,
      OP_LOCATE    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic       take;
      logic       clr_step;
      logic       load_query;
      logic       rd_valid;
      logic       rd_nbr;
      logic       rd_ofs;
      logic       rd_mat;
      logic       cap_ofs;
      logic       mul;
      logic       acc_clr;
      logic       acc_add;
      logic       cap_coord;
      logic       hop_nbr;
      logic       hop_next;
      logic       cyc_inc;
      logic       scan_init;
      logic       scan_next;
      logic       res_load;
      logic       res_found;
      logic       res_scan;
      logic [1:0] k;
      logic [1:0] j;
   } spl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic walk_stop;
      logic cur_oob;
      logic flag;
      logic nbr_differs;
      logic nbr_edge;
      logic c_low;
      logic c_high;
   } spl_status_type;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 44'sd2147483647;
      lo = -44'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[Q_W-1:0];
   endfunction

endpackage

// ===== sv/spl_ram.sv =====
// ----------------------------------------------------------------------------
// spl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/spl_ctrl.sv =====
// ----------------------------------------------------------------------------
// spl_ctrl
// Sequencer for table writes, the directed walk and the fallback scan.
// ----------------------------------------------------------------------------
module spl_ctrl
   import spl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_opcode,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  spl_status_type st,
   output spl_cmd_type    cmd
);

   typedef enum logic [15:0] {
      S_CLEAR  = 16'b0000000000000001,
      S_IDLE   = 16'b0000000000000010,
      S_WCHECK = 16'b0000000000000100,
      S_VRD    = 16'b0000000000001000,
      S_VUSE   = 16'b0000000000010000,
      S_NRD    = 16'b0000000000100000,
      S_NUSE   = 16'b0000000001000000,
      S_ORD    = 16'b0000000010000000,
      S_OUSE   = 16'b0000000100000000,
      S_TRD    = 16'b0000001000000000,
      S_TMUL   = 16'b0000010000000000,
      S_TACC   = 16'b0000100000000000,
      S_CCAP   = 16'b0001000000000000,
      S_CCHK   = 16'b0010000000000000,
      S_SCHECK = 16'b0100000000000000,
      S_DONE   = 16'b1000000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] j_ff, j_in;
   logic       hop_ff, hop_in;
   logic       over_ff, over_in;
   logic       found_ff, found_in;
   logic       scan_ff, scan_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      hop_in       = hop_ff;
      over_in      = over_ff;
      found_in     = found_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_stall    = (state_ff != S_IDLE);
      cmd          = '0;
      cmd.k        = k_ff;
      cmd.j        = j_ff;
      cmd.res_found = found_ff;
      cmd.res_scan  = scan_ff;
      cmd.take      = req_valid & ~req_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.take && opcode_type'(req_opcode) == OP_LOCATE) begin
               cmd.load_query = 1'b1;
               found_in       = 1'b0;
               scan_in        = 1'b0;
               state_in       = S_WCHECK;
            end
         end
         S_WCHECK: begin
            if (st.walk_stop || st.cur_oob) begin
               cmd.scan_init = 1'b1;
               scan_in       = 1'b1;
               state_in      = S_SCHECK;
            end else begin
               state_in = S_VRD;
            end
         end
         S_VRD: begin
            cmd.rd_valid = 1'b1;
            state_in     = S_VUSE;
         end
         S_VUSE: begin
            if (!st.flag) begin
               if (scan_ff) begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_SCHECK;
               end else begin
                  hop_in   = 1'b1;
                  k_in     = 2'd0;
                  state_in = S_NRD;
               end
            end else begin
               j_in     = 2'd0;
               k_in     = 2'd0;
               over_in  = 1'b0;
               state_in = S_ORD;
            end
         end
         S_NRD: begin
            cmd.rd_nbr = 1'b1;
            state_in   = S_NUSE;
         end
         S_NUSE: begin
            if (hop_ff) begin
               if (st.nbr_differs) begin
                  cmd.hop_nbr = 1'b1;
                  cmd.cyc_inc = 1'b1;
                  state_in    = S_WCHECK;
               end else if (k_ff == LAST_K) begin
                  cmd.hop_next = 1'b1;
                  cmd.cyc_inc  = 1'b1;
                  state_in     = S_WCHECK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_NRD;
               end
            end else if (st.nbr_edge) begin
               cmd.scan_init = 1'b1;
               scan_in       = 1'b1;
               state_in      = S_SCHECK;
            end else begin
               cmd.hop_nbr = 1'b1;
               cmd.cyc_inc = 1'b1;
               state_in    = S_WCHECK;
            end
         end
         S_ORD: begin
            cmd.rd_ofs = 1'b1;
            state_in   = S_OUSE;
         end
         S_OUSE: begin
            cmd.cap_ofs = 1'b1;
            if (j_ff == LAST_J) begin
               j_in        = 2'd0;
               cmd.acc_clr = 1'b1;
               state_in    = S_TRD;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = S_ORD;
            end
         end
         S_TRD: begin
            cmd.rd_mat = 1'b1;
            state_in   = S_TMUL;
         end
         S_TMUL: begin
            cmd.mul  = 1'b1;
            state_in = S_TACC;
         end
         S_TACC: begin
            cmd.acc_add = 1'b1;
            if (j_ff == LAST_J) begin
               j_in     = 2'd0;
               state_in = S_CCAP;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = S_TRD;
            end
         end
         S_CCAP: begin
            cmd.cap_coord = 1'b1;
            cmd.acc_clr   = 1'b1;
            state_in      = S_CCHK;
         end
         S_CCHK: begin
            if (scan_ff) begin
               if (st.c_low || st.c_high) begin
                  cmd.scan_next = 1'b1;
                  state_in      = S_SCHECK;
               end else if (k_ff == LAST_K) begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = (k_ff == LAST_J) ? S_CCAP : S_TRD;
               end
            end else if (st.c_low) begin
               hop_in   = 1'b0;
               state_in = S_NRD;
            end else if (k_ff == LAST_K) begin
               if (over_ff || st.c_high) begin
                  cmd.scan_init = 1'b1;
                  scan_in       = 1'b1;
                  state_in      = S_SCHECK;
               end else begin
                  found_in = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               over_in  = over_ff | st.c_high;
               k_in     = k_ff + 2'd1;
               state_in = (k_ff == LAST_J) ? S_CCAP : S_TRD;
            end
         end
         S_SCHECK: begin
            if (st.cur_oob) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               state_in = S_VRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         k_ff         <= 2'd0;
         j_ff         <= 2'd0;
         hop_ff       <= 1'b0;
         over_ff      <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         hop_ff       <= hop_in;
         over_ff      <= over_in;
         found_ff     <= found_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/spl_datapath.sv =====
// ----------------------------------------------------------------------------
// spl_datapath
// Table memories, configuration registers, walk pointers and the shared
// multiply-accumulate unit for barycentric coordinates.
// ----------------------------------------------------------------------------
module spl_datapath
   import spl_pkg::*;
#(
   parameter int MAX_SIMPLICES = MAX_SIMPLICES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_opcode,
   input  logic [IDX_W-1:0]            req_simplex_index,
   input  logic [3:0]                  req_entry_index,
   input  logic signed [Q_W-1:0]       req_entry_value,
   input  logic signed [NBR_W-1:0]     req_neighbor_value,
   input  logic                        req_valid_bit,
   input  logic signed [Q_W-1:0]       req_point_x,
   input  logic signed [Q_W-1:0]       req_point_y,
   input  logic signed [Q_W-1:0]       req_point_z,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_data,
   input  spl_cmd_type                 cmd,
   output spl_status_type              st,
   output logic                        rsp_found,
   output logic [IDX_W-1:0]            rsp_located_simplex,
   output logic                        rsp_used_scan,
   output logic signed [Q_W-1:0]       rsp_bary_0,
   output logic signed [Q_W-1:0]       rsp_bary_1,
   output logic signed [Q_W-1:0]       rsp_bary_2,
   output logic signed [Q_W-1:0]       rsp_bary_3
);

   localparam int SW  = $clog2(MAX_SIMPLICES);
   localparam int TAW = $clog2(MAX_SIMPLICES * TWORDS);
   localparam int NAW = $clog2(MAX_SIMPLICES * NSLOTS);
   localparam int CAP = (MAX_SIMPLICES < 2047) ? MAX_SIMPLICES : 2047;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        start_ff, start_in;
   logic [TOL_W-1:0]        tol_ff, tol_in;
   logic [SW-1:0]           clr_cnt_ff, clr_cnt_in;
   logic signed [CUR_W-1:0] cur_ff, cur_in;
   logic signed [CUR_W-1:0] from_ff, from_in;
   logic signed [CUR_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]        cyc_ff, cyc_in;

   logic signed [Q_W-1:0]   x_ff [NDIM];
   logic signed [Q_W-1:0]   x_in [NDIM];
   logic signed [Q_W:0]     diff_ff [NDIM];
   logic signed [Q_W:0]     diff_in [NDIM];
   logic signed [2*Q_W:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [Q_W-1:0]   c_ff [NDIM+1];
   logic signed [Q_W-1:0]   c_in [NDIM+1];

   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        simplex_ff, simplex_in;
   logic                    used_scan_ff, used_scan_in;
   logic signed [Q_W-1:0]   bary_ff [NDIM+1];
   logic signed [Q_W-1:0]   bary_in [NDIM+1];

   logic [CNT_W-1:0]        cnt;
   logic [CNT_W-1:0]        limit;
   logic [CNT_W-1:0]        cur_lo;
   logic signed [CUR_W-1:0] cur_init;
   logic signed [CUR_W-1:0] nbr_norm;
   logic                    wr_in_range;
   opcode_type              op;

   logic                    t_we, n_we, v_we;
   logic [TAW-1:0]          t_waddr, t_raddr;
   logic [NAW-1:0]          n_waddr, n_raddr;
   logic [SW-1:0]           v_waddr, v_raddr;
   logic                    v_wdata;
   logic [Q_W-1:0]          t_rd_data;
   logic [NBR_W-1:0]        n_rd_data;
   logic                    v_rd_data;

   logic signed [2*Q_W+1:0] psum;
   logic signed [ACC_W-1:0] last_sum;
   logic signed [Q_W-1:0]   c_sel;
   logic signed [33:0]      cv;
   logic signed [33:0]      tv;

   assign op     = opcode_type'(req_opcode);
   assign cnt    = (count_ff > CNT_W'(CAP)) ? CNT_W'(CAP) : count_ff;
   assign limit  = (cnt >> 2) + CNT_W'(1);
   assign cur_lo = cur_ff[CNT_W-1:0];
   assign cur_init = (prev_ff[CUR_W-1] || prev_ff[CNT_W-1:0] >= cnt) ?
                     CUR_W'(start_ff) : prev_ff;
   assign nbr_norm = n_rd_data[NBR_W-1] ? '1 : CUR_W'(n_rd_data);
   assign wr_in_range = 32'(req_simplex_index) < MAX_SIMPLICES;

   // table writes and reads
   assign t_we    = cmd.take && op == OP_TRANSFORM && wr_in_range &&
                    req_entry_index < 4'(TWORDS);
   assign n_we    = cmd.take && op == OP_NEIGHBOR && wr_in_range &&
                    req_entry_index < 4'(NSLOTS);
   assign v_we    = cmd.clr_step || (cmd.take && op == OP_VALID && wr_in_range);
   assign t_waddr = TAW'(req_simplex_index) * TAW'(TWORDS) + TAW'(req_entry_index);
   assign n_waddr = NAW'(req_simplex_index) * NAW'(NSLOTS) + NAW'(req_entry_index);
   assign v_waddr = cmd.clr_step ? clr_cnt_ff : SW'(req_simplex_index);
   assign v_wdata = cmd.clr_step ? 1'b0 : req_valid_bit;
   assign t_raddr = TAW'(cur_lo) * TAW'(TWORDS) +
                    (cmd.rd_ofs ? TAW'(OFS_BASE) + TAW'(cmd.j)
                                : TAW'(cmd.k) * TAW'(NDIM) + TAW'(cmd.j));
   assign n_raddr = NAW'(cur_lo) * NAW'(NSLOTS) + NAW'(cmd.k);
   assign v_raddr = SW'(cur_lo);

   spl_ram #(.WIDTH(Q_W), .DEPTH(MAX_SIMPLICES * TWORDS)) u_transform_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (req_entry_value),
      .rd_addr (t_raddr),
      .rd_data (t_rd_data)
   );

   spl_ram #(.WIDTH(NBR_W), .DEPTH(MAX_SIMPLICES * NSLOTS)) u_neighbor_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (req_neighbor_value),
      .rd_addr (n_raddr),
      .rd_data (n_rd_data)
   );

   spl_ram #(.WIDTH(1), .DEPTH(MAX_SIMPLICES)) u_valid_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rd_data)
   );

   // coordinate arithmetic
   assign psum = (2*Q_W+2)'(prod_ff) + 66'sd8388608;
   assign c_sel = c_ff[cmd.k];
   assign cv = 34'(c_sel);
   assign tv = 34'(tol_ff);

   always_comb begin
      last_sum = 44'sd16777216;
      for (int i = 0; i < NDIM; i++) begin
         last_sum = last_sum - ACC_W'(c_ff[i]);
      end
   end

   // status
   assign st.clr_last    = (clr_cnt_ff == SW'(MAX_SIMPLICES - 1));
   assign st.walk_stop   = (cyc_ff >= limit) || (cur_ff == '1);
   assign st.cur_oob     = cur_ff[CUR_W-1] || (cur_lo >= cnt);
   assign st.flag        = v_rd_data;
   assign st.nbr_differs = (nbr_norm != from_ff);
   assign st.nbr_edge    = (nbr_norm == '1);
   assign st.c_low       = cv < -tv;
   assign st.c_high      = cv > (34'sd16777216 + tv);

   // control registers
   always_comb begin
      count_in   = count_ff;
      start_in   = start_ff;
      tol_in     = tol_ff;
      clr_cnt_in = clr_cnt_ff;
      cur_in     = cur_ff;
      from_in    = from_ff;
      prev_in    = prev_ff;
      cyc_in     = cyc_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COUNT:     count_in = csr_data[CNT_W-1:0];
            CSR_START:     start_in = csr_data[IDX_W-1:0];
            CSR_TOLERANCE: tol_in   = csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + SW'(1);
      end
      priority if (cmd.load_query) begin
         cur_in  = cur_init;
         from_in = '1;
         cyc_in  = '0;
      end else if (cmd.hop_nbr) begin
         from_in = cur_ff;
         cur_in  = nbr_norm;
      end else if (cmd.hop_next) begin
         from_in = cur_ff;
         cur_in  = cur_ff + CUR_W'(1);
      end else if (cmd.scan_init) begin
         cur_in = '0;
      end else if (cmd.scan_next) begin
         cur_in = cur_ff + CUR_W'(1);
      end
      if (cmd.cyc_inc) begin
         cyc_in = cyc_ff + CNT_W'(1);
      end
      if (cmd.res_load) begin
         prev_in = cmd.res_found ? cur_ff : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         start_ff   <= '0;
         tol_ff     <= TOL_RESET;
         clr_cnt_ff <= '0;
         cur_ff     <= '0;
         from_ff    <= '1;
         prev_ff    <= '1;
         cyc_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         start_ff   <= start_in;
         tol_ff     <= tol_in;
         clr_cnt_ff <= clr_cnt_in;
         cur_ff     <= cur_in;
         from_ff    <= from_in;
         prev_ff    <= prev_in;
         cyc_ff     <= cyc_in;
      end
   end

   // payload registers
   always_comb begin
      x_in         = x_ff;
      diff_in      = diff_ff;
      c_in         = c_ff;
      bary_in      = bary_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      found_in     = found_ff;
      simplex_in   = simplex_ff;
      used_scan_in = used_scan_ff;
      if (cmd.load_query) begin
         x_in[0] = req_point_x;
         x_in[1] = req_point_y;
         x_in[2] = req_point_z;
      end
      if (cmd.cap_ofs) begin
         diff_in[cmd.j] = (Q_W+1)'(x_ff[cmd.j]) - (Q_W+1)'($signed(t_rd_data));
      end
      if (cmd.mul) begin
         prod_in = $signed(t_rd_data) * diff_ff[cmd.j];
      end
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(psum >>> 24);
      end
      if (cmd.cap_coord) begin
         c_in[cmd.k] = (cmd.k == LAST_K) ? sat32(last_sum) : sat32(acc_ff);
      end
      if (cmd.res_load) begin
         found_in     = cmd.res_found;
         simplex_in   = cmd.res_found ? cur_ff[IDX_W-1:0] : '0;
         used_scan_in = cmd.res_scan;
         for (int i = 0; i <= NDIM; i++) begin
            bary_in[i] = cmd.res_found ? c_ff[i] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      c_ff         <= c_in;
      found_ff     <= found_in;
      simplex_ff   <= simplex_in;
      used_scan_ff <= used_scan_in;
      bary_ff      <= bary_in;
   end

   assign rsp_found           = found_ff;
   assign rsp_located_simplex = simplex_ff;
   assign rsp_used_scan       = used_scan_ff;
   assign rsp_bary_0          = bary_ff[0];
   assign rsp_bary_1          = bary_ff[1];
   assign rsp_bary_2          = bary_ff[2];
   assign rsp_bary_3          = bary_ff[3];

endmodule

// ===== sv/simplex_point_locator.sv =====
// ----------------------------------------------------------------------------
// simplex_point_locator
// Point location in a loaded simplex table by directed walk with scan fallback.
// ----------------------------------------------------------------------------
// After reset the valid flags are cleared in a pass over all MAX_SIMPLICES
// entries with req_stall high. A write transaction (transform word,
// neighbor, valid flag) is written in the cycle it is taken. A locate
// transaction runs one simplex at a time through one shared multiplier and
// single-port table reads: a degenerate simplex is hopped by reading its
// neighbor slots in turn past those that lead back, and a valid one is
// tested by the step check and flag read, the offsets, each matrix row and
// the last coordinate, then the neighbor the walk steps to is read. The walk
// visits at most 1+count/4 simplices; when it gives up, the scan tests
// simplices in index order, up to count of them. The result is held in an
// output register and a new transaction is taken while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module simplex_point_locator
   import spl_pkg::*;
#(
   parameter int MAX_SIMPLICES = MAX_SIMPLICES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_opcode,
   input  logic [IDX_W-1:0]        req_simplex_index,
   input  logic [3:0]              req_entry_index,
   input  logic signed [Q_W-1:0]   req_entry_value,
   input  logic signed [NBR_W-1:0] req_neighbor_value,
   input  logic                    req_valid_bit,
   input  logic signed [Q_W-1:0]   req_point_x,
   input  logic signed [Q_W-1:0]   req_point_y,
   input  logic signed [Q_W-1:0]   req_point_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic [IDX_W-1:0]        rsp_located_simplex,
   output logic                    rsp_used_scan,
   output logic signed [Q_W-1:0]   rsp_bary_0,
   output logic signed [Q_W-1:0]   rsp_bary_1,
   output logic signed [Q_W-1:0]   rsp_bary_2,
   output logic signed [Q_W-1:0]   rsp_bary_3,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data
);

   spl_cmd_type    cmd;
   spl_status_type st;

   spl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .st         (st),
      .cmd        (cmd)
   );

   spl_datapath #(.MAX_SIMPLICES(MAX_SIMPLICES)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_simplex_index   (req_simplex_index),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .req_neighbor_value  (req_neighbor_value),
      .req_valid_bit       (req_valid_bit),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .st                  (st),
      .rsp_found           (rsp_found),
      .rsp_located_simplex (rsp_located_simplex),
      .rsp_used_scan       (rsp_used_scan),
      .rsp_bary_0          (rsp_bary_0),
      .rsp_bary_1          (rsp_bary_1),
      .rsp_bary_2          (rsp_bary_2),
      .rsp_bary_3          (rsp_bary_3)
   );

   `ASSERT_SAME(a_clear_blocks_req, clock, reset, cmd.clr_step, req_stall, "transaction taken during flag clear")
   `ASSERT_NEXT(a_load_shows_rsp, clock, reset, cmd.res_load, rsp_valid, "loaded result not presented")
   `ASSERT_SAME(a_one_read_kind, clock, reset, 1'b1, $onehot0({cmd.rd_valid, cmd.rd_nbr, cmd.rd_ofs, cmd.rd_mat}), "conflicting table reads")
   `ASSERT_SAME(a_miss_after_scan, clock, reset, rsp_valid && !rsp_found, rsp_used_scan, "miss reported without scan")

endmodule
